// ===== sv/eraa_pkg.sv =====
// shared types, constants and the arctangent table for the euler rate block
package eraa_pkg;

   localparam int REQ_W  = 136;
   localparam int RSP_W  = 208;
   localparam int CSR_AW = 1;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_UPDATE_RATE = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_GRAVITY     = 1'd1;

   localparam logic [15:0] RATE_RESET = 16'd250;
   localparam logic [14:0] GRAV_RESET = 15'd10035;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int ITER_W           = $clog2(ATAN_LEN);
   localparam int CW               = 20;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 20'sd39797;
   localparam logic signed [CW-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [CW-1:0] HALF_PI_Q16 = 20'sd102944;

   typedef struct packed {
      logic                 done;
      logic signed [CW-1:0] cos_v;
      logic signed [CW-1:0] sin_v;
   } cordic_res_type;

   // atan(2^-i) at 2^-16 rad
   function automatic logic signed [CW-1:0] atan_q16(input logic [ITER_W-1:0] idx);
      logic signed [CW-1:0] r;
      case (idx)
         5'd0:  r = 20'sd51472;
         5'd1:  r = 20'sd30386;
         5'd2:  r = 20'sd16055;
         5'd3:  r = 20'sd8150;
         5'd4:  r = 20'sd4091;
         5'd5:  r = 20'sd2047;
         5'd6:  r = 20'sd1024;
         5'd7:  r = 20'sd512;
         5'd8:  r = 20'sd256;
         5'd9:  r = 20'sd128;
         5'd10: r = 20'sd64;
         5'd11: r = 20'sd32;
         5'd12: r = 20'sd16;
         5'd13: r = 20'sd8;
         5'd14: r = 20'sd4;
         5'd15: r = 20'sd2;
         5'd16: r = 20'sd1;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/eraa_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
module eraa_cordic #(
   parameter int STEPS = eraa_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [15:0]           angle,
   output eraa_pkg::cordic_res_type     res
);
   import eraa_pkg::*;

   localparam int EFF_STEPS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(EFF_STEPS - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [ITER_W-1:0]    iter_ff;
   logic signed [CW-1:0] x_ff, y_ff, z_ff;

   logic signed [CW-1:0] z_start, xs, ys, at;

   always_comb begin
      z_start = {angle[15], angle, 3'b000};
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = atan_q16(iter_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (iter_ff == LAST_ITER);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (iter_ff == LAST_ITER)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         iter_ff <= '0;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         // fold angles beyond a quarter turn, sign fixed at the output
         if (z_start > HALF_PI_Q16) begin
            z_ff   <= z_start - PI_Q16;
            neg_ff <= 1'b1;
         end else if (z_start < -HALF_PI_Q16) begin
            z_ff   <= z_start + PI_Q16;
            neg_ff <= 1'b1;
         end else begin
            z_ff   <= z_start;
            neg_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         iter_ff <= iter_ff + 1'b1;
         if (!z_ff[CW-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   assign res.done  = done_ff;
   assign res.cos_v = neg_ff ? -x_ff : x_ff;
   assign res.sin_v = neg_ff ? -y_ff : y_ff;

endmodule

// ===== sv/euler_rate_to_angular_accel.sv =====
// euler rate to angular velocity and angular acceleration, top level
// One word at a time: after a request word is taken the block runs the pitch angle and then
// the yaw angle through a shared iterative CORDIC, then pushes ten products through one
// registered 20x20 multiplier, one a cycle. req_tready is high only while idle; a finished
// result waits in the output register until taken and the next word may already be accepted.
// The previous angular velocity is cleared by reset.
module euler_rate_to_angular_accel #(
   parameter int CORDIC_STEPS = eraa_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // lin_acc_x, lin_acc_y, lin_acc_z, pitch_angle, yaw_angle, rate_x, rate_y, rate_z
   input  logic [eraa_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_lin_x, out_lin_y, out_lin_z, omega_x, omega_y, omega_z, ang_acc_x, ang_acc_y, ang_acc_z
   output logic [eraa_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [eraa_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [eraa_pkg::CSR_DW-1:0]   csr_wdata
);
   import eraa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PITCH = 3'd1;
   localparam logic [2:0] S_YAW   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   localparam logic [3:0] OP_CYCZ    = 4'd0;
   localparam logic [3:0] OP_CYSZ    = 4'd1;
   localparam logic [3:0] OP_CYCZ_RX = 4'd2;
   localparam logic [3:0] OP_SZ_RY   = 4'd3;
   localparam logic [3:0] OP_CYSZ_RX = 4'd4;
   localparam logic [3:0] OP_CZ_RY   = 4'd5;
   localparam logic [3:0] OP_SY_RX   = 4'd6;
   localparam logic [3:0] OP_ACC_X   = 4'd7;
   localparam logic [3:0] OP_ACC_Y   = 4'd8;
   localparam logic [3:0] OP_ACC_Z   = 4'd9;
   localparam logic [3:0] MUL_LAST   = 4'd10;

   function automatic logic signed [24:0] rnd16(input logic signed [40:0] v);
      logic signed [40:0] t;
      t = v + 41'sd32768;
      return t[40:16];
   endfunction

   function automatic logic signed [16:0] sat17(input logic signed [24:0] v);
      logic signed [16:0] r;
      if (v > 25'sd65535)       r = 17'sd65535;
      else if (v < -25'sd65536) r = -17'sd65536;
      else                      r = v[16:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -40'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   logic [15:0] rate_ff;
   logic [14:0] grav_ff;

   logic signed [17:0] lx_ff, ly_ff, lz_ff;
   logic signed [15:0] yaw_ff, rx_ff, ry_ff, rz_ff;
   logic signed [CW-1:0] cy_ff, sy_ff, cz_ff, sz_ff, cycz_ff, cysz_ff;
   logic signed [39:0] prod_ff;
   logic signed [40:0] acc_ff;
   logic signed [16:0] w_ff    [3];
   logic signed [16:0] prev_ff [3];
   logic signed [31:0] aacc_ff [3];
   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic                 accept, load_out;
   logic signed [15:0]   cord_angle;
   cordic_res_type       cord_res;
   logic signed [CW-1:0] mul_a, mul_b;
   logic signed [17:0]   diff [3];
   logic [3:0]           proc_op;
   logic signed [40:0]   prod_ext;
   logic signed [18:0]   out_z;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == S_FIN) && (!rsp_tvalid_ff || rsp_tready);
   assign cord_angle = (state_ff == S_IDLE) ? signed'(req_tdata[69:54]) : yaw_ff;

   eraa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept || ((state_ff == S_PITCH) && cord_res.done)),
      .angle (cord_angle),
      .res   (cord_res)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         grav_ff <= GRAV_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_UPDATE_RATE: rate_ff <= csr_wdata;
            CSR_GRAVITY:     grav_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_PITCH;
         S_PITCH: if (cord_res.done) state_in = S_YAW;
         S_YAW: begin
            if (cord_res.done) begin
               state_in = S_MUL;
               op_in    = '0;
            end
         end
         S_MUL: begin
            op_in = op_ff + 1'b1;
            if (op_ff == MUL_LAST) state_in = S_FIN;
         end
         S_FIN:   if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // shared multiplier operand select
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = {w_ff[k][16], w_ff[k]} - {prev_ff[k][16], prev_ff[k]};
      end
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_CYCZ:    begin mul_a = cy_ff;   mul_b = cz_ff; end
         OP_CYSZ:    begin mul_a = cy_ff;   mul_b = sz_ff; end
         OP_CYCZ_RX: begin mul_a = cycz_ff; mul_b = CW'(rx_ff); end
         OP_SZ_RY:   begin mul_a = sz_ff;   mul_b = CW'(ry_ff); end
         OP_CYSZ_RX: begin mul_a = cysz_ff; mul_b = CW'(rx_ff); end
         OP_CZ_RY:   begin mul_a = cz_ff;   mul_b = CW'(ry_ff); end
         OP_SY_RX:   begin mul_a = sy_ff;   mul_b = CW'(rx_ff); end
         OP_ACC_X:   begin mul_a = CW'(diff[0]); mul_b = signed'({4'b0, rate_ff}); end
         OP_ACC_Y:   begin mul_a = CW'(diff[1]); mul_b = signed'({4'b0, rate_ff}); end
         OP_ACC_Z:   begin mul_a = CW'(diff[2]); mul_b = signed'({4'b0, rate_ff}); end
         default: ;
      endcase
   end

   // product of the previous op is registered and consumed in the next cycle
   assign proc_op  = op_ff - 1'b1;
   assign prod_ext = {prod_ff[39], prod_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         lx_ff  <= signed'(req_tdata[17:0]);
         ly_ff  <= signed'(req_tdata[35:18]);
         lz_ff  <= signed'(req_tdata[53:36]);
         yaw_ff <= signed'(req_tdata[85:70]);
         rx_ff  <= signed'(req_tdata[101:86]);
         ry_ff  <= signed'(req_tdata[117:102]);
         rz_ff  <= signed'(req_tdata[133:118]);
      end
      if ((state_ff == S_PITCH) && cord_res.done) begin
         cy_ff <= cord_res.cos_v;
         sy_ff <= cord_res.sin_v;
      end
      if ((state_ff == S_YAW) && cord_res.done) begin
         cz_ff <= cord_res.cos_v;
         sz_ff <= cord_res.sin_v;
      end
      prod_ff <= mul_a * mul_b;
      if ((state_ff == S_MUL) && (op_ff != '0)) begin
         case (proc_op)
            OP_CYCZ:    cycz_ff <= CW'(rnd16(prod_ext));
            OP_CYSZ:    cysz_ff <= CW'(rnd16(prod_ext));
            OP_CYCZ_RX: acc_ff  <= prod_ext;
            OP_SZ_RY:   w_ff[0] <= sat17(rnd16(acc_ff - prod_ext));
            OP_CYSZ_RX: acc_ff  <= prod_ext;
            OP_CZ_RY:   w_ff[1] <= sat17(rnd16(acc_ff + prod_ext));
            OP_SY_RX:   w_ff[2] <= sat17(rnd16({{9{rz_ff[15]}}, rz_ff, 16'b0} - prod_ext));
            OP_ACC_X:   aacc_ff[0] <= sat32(prod_ff);
            OP_ACC_Y:   aacc_ff[1] <= sat32(prod_ff);
            OP_ACC_Z:   aacc_ff[2] <= sat32(prod_ff);
            default: ;
         endcase
      end
   end

   // previous angular velocity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) prev_ff[k] <= '0;
      end else if (load_out) begin
         for (int k = 0; k < 3; k++) prev_ff[k] <= w_ff[k];
      end
   end

   // output word register
   assign out_z = {lz_ff[17], lz_ff} + signed'({4'b0, grav_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {4'b0, aacc_ff[2], aacc_ff[1], aacc_ff[0],
                         w_ff[2], w_ff[1], w_ff[0],
                         out_z, ly_ff[17], ly_ff, lx_ff[17], lx_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cordic_done_in_angle_state: assert property (@(posedge clock) disable iff (reset)
      cord_res.done |-> ((state_ff == S_PITCH) || (state_ff == S_YAW)))
      else $error("cordic finished outside an angle phase");

   a_accept_starts_pitch: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PITCH))
      else $error("accepted word did not start the pitch phase");

   a_op_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (op_ff <= MUL_LAST))
      else $error("multiplier op counter out of range");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_tvalid && (state_ff == S_IDLE)))
      else $error("result word not presented after load");

endmodule

// ===== test/euler_rate_to_angular_accel_test.sv =====
// self-checking testbench for the euler rate to angular acceleration block
module euler_rate_to_angular_accel_test;
   timeunit 1ns;
   timeprecision 1ps;
   import eraa_pkg::*;

   localparam int STEPS      = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
   localparam int SETTLE     = 64;
   localparam int LIMIT      = 1000000;
   localparam int PHASE_LEN  = 225;
   localparam longint K_GAIN    = 39797;
   localparam longint K_PI      = 205887;
   localparam longint K_HALF_PI = 102944;

   // request word, first field in the lowest bits
   typedef struct packed {
      logic [1:0]         pad;
      logic signed [15:0] rate_z;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_x;
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [17:0] lin_z;
      logic signed [17:0] lin_y;
      logic signed [17:0] lin_x;
   } req_word_type;

   // response word, first field in the lowest bits
   typedef struct packed {
      logic [3:0]         pad;
      logic signed [31:0] acc_z;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_x;
      logic signed [16:0] om_z;
      logic signed [16:0] om_y;
      logic signed [16:0] om_x;
      logic signed [18:0] lin_z;
      logic signed [18:0] lin_y;
      logic signed [18:0] lin_x;
   } rsp_word_type;

   typedef struct {
      bit                is_csr;
      logic [CSR_AW-1:0] addr;
      logic [15:0]       wdata;
      req_word_type      req;
      bit                pinned;
      rsp_word_type      rsp;
   } step_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   req_word_type      req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   // typed-in expectation travels with the word it belongs to
   bit                pin_flag = 1'b0;
   rsp_word_type      pin_rsp = '0;

   int                cycles = 0;
   int                fault_count = 0;
   int                hold_off = 0;

   // mirror of the block's registers and velocity history
   longint            rate_reg = 250;
   longint            grav_reg = 10035;
   longint            omega_prev [3] = '{0, 0, 0};
   rsp_word_type      motion_due [$];
   step_type          plan [$];

   longint atan_lut [0:23] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

   euler_rate_to_angular_accel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint rnd16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // rotation-mode cordic, angle at 2^-13 rad, results in q16
   function automatic void sin_cos(input longint ang, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit     flip;
      z = ang * 8;
      x = K_GAIN;
      y = 0;
      flip = 1'b0;
      if (z > K_HALF_PI) begin
         z -= K_PI;
         flip = 1'b1;
      end else if (z < -K_HALF_PI) begin
         z += K_PI;
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z -= atan_lut[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z += atan_lut[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic rsp_word_type predict_motion(input req_word_type q);
      longint       cy, sy, cz, sz, cycz, cysz, rx, ry, rz;
      longint       w [3];
      longint       a [3];
      rsp_word_type r;
      rx = q.rate_x;
      ry = q.rate_y;
      rz = q.rate_z;
      sin_cos(q.pitch, cy, sy);
      sin_cos(q.yaw, cz, sz);
      cycz = rnd16(cy * cz);
      cysz = rnd16(cy * sz);
      w[0] = rnd16(cycz * rx - sz * ry);
      w[1] = rnd16(cysz * rx + cz * ry);
      w[2] = rnd16(-sy * rx + rz * 65536);
      for (int k = 0; k < 3; k++) begin
         w[k] = clamp(w[k], -65536, 65535);
         a[k] = clamp((w[k] - omega_prev[k]) * rate_reg, -64'sd2147483648, 64'sd2147483647);
         omega_prev[k] = w[k];
      end
      r = '0;
      r.lin_x = q.lin_x;
      r.lin_y = q.lin_y;
      r.lin_z = longint'(q.lin_z) + grav_reg;
      r.om_x = w[0];
      r.om_y = w[1];
      r.om_z = w[2];
      r.acc_x = a[0];
      r.acc_y = a[1];
      r.acc_z = a[2];
      return r;
   endfunction

   task automatic report_field(input string name, input longint e, input longint a);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", name, e, a);
   endtask

   task automatic check_motion(input rsp_word_type e, input rsp_word_type a);
      if (e.lin_x != a.lin_x) report_field("out_lin_x", e.lin_x, a.lin_x);
      if (e.lin_y != a.lin_y) report_field("out_lin_y", e.lin_y, a.lin_y);
      if (e.lin_z != a.lin_z) report_field("out_lin_z", e.lin_z, a.lin_z);
      if (e.om_x != a.om_x) report_field("omega_x", e.om_x, a.om_x);
      if (e.om_y != a.om_y) report_field("omega_y", e.om_y, a.om_y);
      if (e.om_z != a.om_z) report_field("omega_z", e.om_z, a.om_z);
      if (e.acc_x != a.acc_x) report_field("ang_acc_x", e.acc_x, a.acc_x);
      if (e.acc_y != a.acc_y) report_field("ang_acc_y", e.acc_y, a.acc_y);
      if (e.acc_z != a.acc_z) report_field("ang_acc_z", e.acc_z, a.acc_z);
   endtask

   // register writes, accepted words and returned words, all seen at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         rate_reg = 250;
         grav_reg = 10035;
         for (int k = 0; k < 3; k++) omega_prev[k] = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_UPDATE_RATE: rate_reg = csr_wdata;
               CSR_GRAVITY:     grav_reg = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (pin_flag) begin
               void'(predict_motion(req_tdata));
               motion_due.push_back(pin_rsp);
            end else begin
               motion_due.push_back(predict_motion(req_tdata));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (motion_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) $display("response word with nothing outstanding");
            end else begin
               check_motion(motion_due.pop_front(), rsp_word_type'(rsp_tdata));
            end
         end
      end
   end

   always @(posedge clock) cycles <= cycles + 1;

   // receiver: free-running, random, long stalls, or a square wave
   always @(posedge clock) begin
      if (hold_off != 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (cycles[11:10])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
               if ($urandom_range(0, 7) == 0) begin
                  hold_off <= $urandom_range(1, 40);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
            default: rsp_tready <= cycles[2];
         endcase
      end
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_word_type mk_req(input int lx, input int ly, input int lz,
                                           input int p, input int y,
                                           input int rx, input int ry, input int rz);
      req_word_type q;
      q = '0;
      q.lin_x = lx;
      q.lin_y = ly;
      q.lin_z = lz;
      q.pitch = p;
      q.yaw = y;
      q.rate_x = rx;
      q.rate_y = ry;
      q.rate_z = rz;
      return q;
   endfunction

   function automatic rsp_word_type mk_lin(input int lx, input int ly, input int lz);
      rsp_word_type r;
      r = '0;
      r.lin_x = lx;
      r.lin_y = ly;
      r.lin_z = lz;
      return r;
   endfunction

   task automatic add_item(input req_word_type q, input bit pin, input rsp_word_type r);
      step_type s;
      s.is_csr = 1'b0;
      s.addr = '0;
      s.wdata = '0;
      s.req = q;
      s.pinned = pin;
      s.rsp = r;
      plan.push_back(s);
   endtask

   task automatic add_csr(input logic [CSR_AW-1:0] a, input logic [15:0] d);
      step_type s;
      s.is_csr = 1'b1;
      s.addr = a;
      s.wdata = d;
      s.req = '0;
      s.pinned = 1'b0;
      s.rsp = '0;
      plan.push_back(s);
   endtask

   function automatic logic [31:0] rand_bits(input int w);
      case ($urandom_range(0, 9))
         0: return 32'd1 << (w - 1);
         1: return (32'd1 << (w - 1)) - 1;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // angles cluster around the fold point at plus and minus half pi
   function automatic logic [15:0] rand_angle();
      int v;
      if ($urandom_range(0, 3) == 0) begin
         v = 12867 + $urandom_range(0, 2);
         if ($urandom_range(0, 1) == 1) v = -v;
         return v;
      end
      return rand_bits(16);
   endfunction

   function automatic req_word_type rand_req();
      req_word_type q;
      q = '0;
      q.lin_x = rand_bits(18);
      q.lin_y = rand_bits(18);
      q.lin_z = rand_bits(18);
      q.pitch = rand_angle();
      q.yaw = rand_angle();
      q.rate_x = rand_bits(16);
      q.rate_y = rand_bits(16);
      q.rate_z = rand_bits(16);
      return q;
   endfunction

   task automatic send_word(input req_word_type d, input bit pin, input rsp_word_type r);
      req_tdata <= d;
      pin_flag <= pin;
      pin_rsp <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every outstanding word has come back and the block is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (motion_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] a, input logic [15:0] d);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int burst_left;
      logic [15:0] rate_set;
      logic [15:0] grav_set;

      // zero rates keep the velocity history at zero, so these rows read off directly
      add_item(mk_req(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_lin(0, 0, 10035));
      add_item(mk_req(131071, -131072, 131071, 32767, -32768, 0, 0, 0), 1'b1,
               mk_lin(131071, -131072, 141106));
      add_item(mk_req(-131072, 131071, -131072, -32768, 32767, 0, 0, 0), 1'b1,
               mk_lin(-131072, 131071, -121037));
      add_item(mk_req(5, -5, 7, 0, 0, 32767, -32768, 32767), 1'b0, '0);
      // exactly half pi stays, one step past it folds
      add_item(mk_req(1, 2, 3, 12868, 12869, -32768, 32767, 32767), 1'b0, '0);
      add_item(mk_req(-1, -2, -3, -12868, -12869, 32767, 0, -32768), 1'b0, '0);
      add_item(mk_req(100, 200, 300, 16384, -16384, 1234, -4321, 777), 1'b0, '0);
      // full rate with swings in omega_z drives the acceleration into saturation
      add_csr(CSR_UPDATE_RATE, 16'hffff);
      add_item(mk_req(0, 0, 0, 12868, 0, -32768, 0, 32767), 1'b0, '0);
      add_item(mk_req(0, 0, 0, 12868, 0, 32767, 0, -32768), 1'b0, '0);
      add_item(mk_req(0, 0, 0, -12868, 6434, 32767, -32768, 32767), 1'b0, '0);
      add_csr(CSR_UPDATE_RATE, 16'd0);
      add_item(mk_req(9, 9, 9, 3000, -3000, 20000, -20000, 12345), 1'b0, '0);
      add_csr(CSR_UPDATE_RATE, 16'd1);
      add_csr(CSR_GRAVITY, 16'd0);
      add_item(mk_req(0, 0, -131072, -6434, 6434, -1, 1, -1), 1'b0, '0);
      add_csr(CSR_GRAVITY, 16'd32767);
      add_item(mk_req(0, 0, 131071, 6434, -6434, 1000, 1000, 1000), 1'b0, '0);
      add_item(mk_req(-7, 7, -1, 25736, -25736, -32768, -32768, -32768), 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_csr(plan[i].addr, plan[i].wdata);
         end else begin
            send_word(plan[i].req, plan[i].pinned, plan[i].rsp);
            pause($urandom_range(0, 3) == 0 ? $urandom_range(1, 50) : 0);
         end
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin rate_set = 16'd250;   grav_set = 16'd10035; end
            1: begin rate_set = 16'hffff;  grav_set = 16'd32767; end
            2: begin rate_set = 16'd1;     grav_set = 16'd0; end
            3: begin rate_set = 16'd0;     grav_set = $urandom_range(0, 32767); end
            4: begin rate_set = $urandom_range(1, 65535); grav_set = $urandom_range(0, 32767); end
            default: begin rate_set = $urandom_range(1, 2000); grav_set = 16'd32767; end
         endcase
         drain();
         write_csr(CSR_UPDATE_RATE, rate_set);
         // let csr_we fall before the next write, so the write enable is not driven twice in one step
         @(posedge clock);
         write_csr(CSR_GRAVITY, grav_set);
         burst_left = 0;
         for (int n = 0; n < PHASE_LEN; n++) begin
            send_word(rand_req(), 1'b0, '0);
            if ($urandom_range(0, 149) == 0) begin
               drain();
            end else if (p != 2) begin
               // phase 2 runs back to back, the others in bursts
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  pause($urandom_range(1, 60));
               end else begin
                  burst_left--;
               end
            end
         end
      end

      drain();
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/eraa_pkg.sv
sv/eraa_cordic.sv
sv/euler_rate_to_angular_accel.sv
test/euler_rate_to_angular_accel_test.sv
